// ===== rtl/core/itd_pkg.sv =====
// Shared constants and types for the integer to decimal text block.
package itd_pkg;

  localparam int VALUE_BITS = 32;
  localparam int MAX_WIDTH  = 16;

  // Digit count of the largest magnitude, 2**(VALUE_BITS-1).
  function automatic int calc_digits(int bits);
    longint unsigned top_val;
    longint unsigned p;
    int              n;
    top_val = 64'd1 << (bits - 1);
    p       = 64'd1;
    n       = 1;
    while (p * 10 <= top_val) begin
      p = p * 10;
      n = n + 1;
    end
    return n;
  endfunction

  localparam int DIGITS     = calc_digits(VALUE_BITS);
  localparam int BCD_BITS   = 4 * DIGITS;
  localparam int TEXT_LEN   = DIGITS + 1;
  localparam int ND_BITS    = $clog2(DIGITS + 1);
  localparam int W_BITS     = $clog2(MAX_WIDTH + 1);
  localparam int DAB_STAGES = 4;
  localparam int DAB_STEPS  = (VALUE_BITS + DAB_STAGES - 1) / DAB_STAGES;
  localparam int MAG_BITS   = DAB_STAGES * DAB_STEPS;

  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 5;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FIELD_WIDTH = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SIGNED_MODE = 1'd1;

  localparam logic [4:0] FIELD_WIDTH_RESET = 5'd11;
  localparam logic       SIGNED_MODE_RESET = 1'b1;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // Double-dabble working word: BCD digits on top, remaining binary below.
  typedef struct packed {
    logic                neg;
    logic [BCD_BITS-1:0] bcd;
    logic [MAG_BITS-1:0] bin;
  } dab_t;

  typedef logic [TEXT_LEN-1:0][7:0] text_t;

endpackage

// ===== rtl/core/itd_dab_stage.sv =====
// One register stage of the binary to BCD converter, a fixed slice of shift steps.
module itd_dab_stage (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  itd_pkg::dab_t in_word,
  input  logic         adv,
  output logic         out_valid,
  output itd_pkg::dab_t out_word,
  output logic         free
);

  itd_pkg::dab_t stepped;

  always_comb begin
    stepped = in_word;
    for (int s = 0; s < itd_pkg::DAB_STEPS; s++) begin
      // add three to any digit of five or more, then shift one bit in
      for (int d = 0; d < itd_pkg::DIGITS; d++) begin
        if (stepped.bcd[4*d +: 4] >= 4'd5) begin
          stepped.bcd[4*d +: 4] = stepped.bcd[4*d +: 4] + 4'd3;
        end
      end
      stepped.bcd = {stepped.bcd[itd_pkg::BCD_BITS-2:0], stepped.bin[itd_pkg::MAG_BITS-1]};
      stepped.bin = {stepped.bin[itd_pkg::MAG_BITS-2:0], 1'b0};
    end
  end

  assign free = !out_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= in_valid;
    end
    if (free) begin
      out_word <= stepped;
    end
  end

endmodule

// ===== rtl/core/itd_text.sv =====
// Text stage: finds the leading digit and lays out sign and ASCII digits left justified.
module itd_text (
  input  logic          clk,
  input  logic          rst,
  input  logic          signed_mode,
  input  logic          in_valid,
  input  itd_pkg::dab_t in_word,
  input  logic          adv,
  output logic          out_valid,
  output itd_pkg::text_t text,
  output logic          free
);

  logic [itd_pkg::ND_BITS-1:0] nd;
  logic [7:0]                  lj [itd_pkg::DIGITS];
  itd_pkg::text_t              text_next;
  logic                        show_sign;

  always_comb begin
    nd = itd_pkg::ND_BITS'(1);
    for (int i = 1; i < itd_pkg::DIGITS; i++) begin
      if (in_word.bcd[4*i +: 4] != 4'd0) begin
        nd = itd_pkg::ND_BITS'(i + 1);
      end
    end
    // lj[j] is the j-th digit counted from the most significant one
    for (int j = 0; j < itd_pkg::DIGITS; j++) begin
      lj[j] = 8'h00;
      for (int i = 0; i < itd_pkg::DIGITS; i++) begin
        if (i + j + 1 == int'(nd)) begin
          lj[j] = itd_pkg::CHAR_ZERO + {4'd0, in_word.bcd[4*i +: 4]};
        end
      end
    end
    // a negative value always has a nonzero magnitude, so no minus zero
    show_sign = in_word.neg && signed_mode;
    text_next[0] = show_sign ? itd_pkg::CHAR_MINUS : lj[0];
    for (int j = 1; j < itd_pkg::DIGITS; j++) begin
      text_next[j] = show_sign ? lj[j-1] : lj[j];
    end
    text_next[itd_pkg::TEXT_LEN-1] = show_sign ? lj[itd_pkg::DIGITS-1] : 8'h00;
  end

  assign free = !out_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= in_valid;
    end
    if (free) begin
      text <= text_next;
    end
  end

endmodule

// ===== rtl/core/itd_serializer.sv =====
// Byte serializer: emits one field of text plus zero padding, one byte per cycle.
module itd_serializer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  itd_pkg::text_t               text,
  input  logic [itd_pkg::W_BITS-1:0]   width,
  output logic                         take,
  output logic                         strobe,
  output logic [7:0]                   char_byte,
  output logic                         is_last
);

  logic                       active;
  logic [itd_pkg::W_BITS-1:0] remaining;
  itd_pkg::text_t             shreg;

  // load the next field as the last byte of this one goes out
  assign take = in_valid && (!active || remaining == itd_pkg::W_BITS'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      strobe    <= 1'b0;
      remaining <= '0;
    end else begin
      strobe <= active;
      if (take) begin
        remaining <= width;
        active    <= 1'b1;
      end else if (active) begin
        remaining <= remaining - 1'b1;
        if (remaining == itd_pkg::W_BITS'(1)) begin
          active <= 1'b0;
        end
      end
    end
    char_byte <= shreg[0];
    is_last   <= active && (remaining == itd_pkg::W_BITS'(1));
    if (take) begin
      shreg <= text;
    end else if (active) begin
      shreg <= {8'h00, shreg[itd_pkg::TEXT_LEN-1:1]};
    end
  end

  a_active_count: assert property (@(posedge clk) disable iff (rst)
    active |-> remaining != '0)
    else $error("serializer active with no bytes left");

  a_field_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !is_last |-> active)
    else $error("field broken off before its last byte");

  a_start_from_input: assert property (@(posedge clk) disable iff (rst)
    $rose(active) |-> $past(in_valid))
    else $error("serializer started without a word");

endmodule

// ===== rtl/core/int_to_decimal_text.sv =====
// Top level: signed integer to fixed-width decimal ASCII field.
// An accepted word passes through six pipeline stages and then the serializer, which sends
// one byte per cycle for field_width bytes (clamped to 1..16).
// The serializer takes one new word per field_width bytes that it sends;
// busy rises only when the six-stage converter pipeline is full. The receiver cannot stall.
// Reset (synchronous, active high) empties the pipeline and restores field_width 11,
// signed_mode 1.
module int_to_decimal_text (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [itd_pkg::VALUE_BITS-1:0] number,
  output logic                                 busy,
  input  logic                                 cfg_write,
  input  logic [itd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [itd_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  output logic                                 strobe,
  output logic [7:0]                           char_byte,
  output logic                                 is_last
);

  logic [4:0] field_width;
  logic       signed_mode;

  itd_pkg::dab_t stage_d    [0:itd_pkg::DAB_STAGES];
  logic          stage_v    [0:itd_pkg::DAB_STAGES];
  logic          stage_free [0:itd_pkg::DAB_STAGES+1];

  logic                           neg_in;
  logic [itd_pkg::VALUE_BITS-1:0] mag_in;
  logic                           text_valid;
  itd_pkg::text_t                 text;
  logic                           take;
  logic [itd_pkg::W_BITS-1:0]     width_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      field_width <= itd_pkg::FIELD_WIDTH_RESET;
      signed_mode <= itd_pkg::SIGNED_MODE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        itd_pkg::REG_FIELD_WIDTH: field_width <= cfg_data;
        itd_pkg::REG_SIGNED_MODE: signed_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (field_width == 5'd0) begin
      width_sat = itd_pkg::W_BITS'(1);
    end else if (int'(field_width) > itd_pkg::MAX_WIDTH) begin
      width_sat = itd_pkg::W_BITS'(itd_pkg::MAX_WIDTH);
    end else begin
      width_sat = itd_pkg::W_BITS'(field_width);
    end
  end

  // front stage: take the magnitude; the most negative value wraps to its true size
  assign neg_in = number[itd_pkg::VALUE_BITS-1];
  assign mag_in = neg_in ? (~number + 1'b1) : number;

  assign stage_free[0] = !stage_v[0] || stage_free[1];
  assign busy          = !stage_free[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v[0] <= 1'b0;
    end else if (stage_free[0]) begin
      stage_v[0] <= start;
    end
    if (stage_free[0]) begin
      stage_d[0].neg <= neg_in;
      stage_d[0].bcd <= '0;
      stage_d[0].bin <= itd_pkg::MAG_BITS'(mag_in);
    end
  end

  for (genvar k = 0; k < itd_pkg::DAB_STAGES; k++) begin : g_dab
    itd_dab_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_v[k]),
      .in_word   (stage_d[k]),
      .adv       (stage_free[k+2]),
      .out_valid (stage_v[k+1]),
      .out_word  (stage_d[k+1]),
      .free      (stage_free[k+1])
    );
  end

  itd_text u_text (
    .clk         (clk),
    .rst         (rst),
    .signed_mode (signed_mode),
    .in_valid    (stage_v[itd_pkg::DAB_STAGES]),
    .in_word     (stage_d[itd_pkg::DAB_STAGES]),
    .adv         (take),
    .out_valid   (text_valid),
    .text        (text),
    .free        (stage_free[itd_pkg::DAB_STAGES+1])
  );

  itd_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (text_valid),
    .text      (text),
    .width     (width_sat),
    .take      (take),
    .strobe    (strobe),
    .char_byte (char_byte),
    .is_last   (is_last)
  );

  a_busy_when_full: assert property (@(posedge clk) disable iff (rst)
    busy |-> stage_v[0] && text_valid && !take)
    else $error("busy raised with room in the pipeline");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> stage_v[0])
    else $error("accepted word lost at the front stage");

  a_no_take_when_empty: assert property (@(posedge clk) disable iff (rst)
    take |-> text_valid)
    else $error("serializer took a word from an empty text stage");

endmodule

// ===== dv/itd_checker.sv =====
// Checker for int_to_decimal_text: tracks registers, predicts each text field, compares bytes.
`timescale 1ns / 100ps

module itd_checker
  import itd_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic signed [VALUE_BITS-1:0]  number,
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  input  logic                          strobe,
  input  logic [7:0]                    char_byte,
  input  logic                          is_last,
  output int                            fail_count,
  output int                            outstanding,
  output int                            bytes_seen
);

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } field_char_t;

  field_char_t chars_due[$];
  field_char_t due;
  logic [4:0]  width_reg;
  logic        sign_reg;

  // Queue the bytes of one word as the block should emit them.
  function automatic void format_field(input logic [VALUE_BITS-1:0] val);
    logic [VALUE_BITS-1:0] mag;
    logic                  neg;
    logic [7:0]            text[$];
    field_char_t           fc;
    int                    width;
    neg = val[VALUE_BITS-1];
    // The most negative value wraps onto its own magnitude as an unsigned word.
    mag = neg ? (~val + 1'b1) : val;
    do begin
      text.push_front(CHAR_ZERO + 8'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (neg && sign_reg)
      text.push_front(CHAR_MINUS);
    width = int'(width_reg);
    if (width < 1)
      width = 1;
    if (width > MAX_WIDTH)
      width = MAX_WIDTH;
    for (int k = 0; k < width; k++) begin
      fc.ch   = (k < text.size()) ? text[k] : 8'h00;
      fc.last = (k == width - 1);
      chars_due.push_back(fc);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      width_reg <= FIELD_WIDTH_RESET;
      sign_reg  <= SIGNED_MODE_RESET;
      chars_due.delete();
      outstanding <= 0;
      fail_count = 0;
      bytes_seen = 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_FIELD_WIDTH)
          width_reg <= cfg_data[4:0];
        else if (cfg_index == REG_SIGNED_MODE)
          sign_reg <= cfg_data[0];
      end
      if (start && !busy)
        format_field(number);
      if (strobe) begin
        bytes_seen++;
        if (chars_due.size() == 0) begin
          $error("char_byte: expected no byte, got 8'h%02h", char_byte);
          fail_count++;
        end else begin
          due = chars_due.pop_front();
          if (char_byte !== due.ch) begin
            $error("char_byte: expected 8'h%02h, got 8'h%02h", due.ch, char_byte);
            fail_count++;
          end
          if (is_last !== due.last) begin
            $error("is_last: expected %0b, got %0b", due.last, is_last);
            fail_count++;
          end
        end
      end
      outstanding <= chars_due.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
// Testbench top for int_to_decimal_text: drives words and register writes, gives the verdict.
`timescale 1ns / 100ps

module tb;
  import itd_pkg::*;

  localparam int IDLE_LIMIT   = 300;
  localparam int DRAIN_CYCLES = 24;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_WORDS  = 50;

  logic                         clk;
  logic                         rst;
  logic                         start;
  logic signed [VALUE_BITS-1:0] number;
  logic                         busy;
  logic                         cfg_write;
  logic [CFG_INDEX_BITS-1:0]    cfg_index;
  logic [CFG_DATA_BITS-1:0]     cfg_data;
  logic                         strobe;
  logic [7:0]                   char_byte;
  logic                         is_last;

  int fail_count;
  int outstanding;
  int bytes_seen;
  int words_sent;
  int settings_used;
  int idle_cycles;
  bit burst;

  int_to_decimal_text uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .number    (number),
    .busy      (busy),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .strobe    (strobe),
    .char_byte (char_byte),
    .is_last   (is_last)
  );

  itd_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .number      (number),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .strobe      (strobe),
    .char_byte   (char_byte),
    .is_last     (is_last),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .bytes_seen  (bytes_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Drop the run if neither a word nor a byte moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (!rst && idle_cycles >= IDLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic send_word(input logic signed [VALUE_BITS-1:0] val);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    number <= val;
    // busy as sampled here is the value the edge acted on
    do @(posedge clk); while (busy);
    words_sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_format(input int width, input bit sign_on);
    wait_idle();
    write_reg(REG_FIELD_WIDTH, CFG_DATA_BITS'(width));
    write_reg(REG_SIGNED_MODE, CFG_DATA_BITS'(sign_on));
    settings_used++;
  endtask

  function automatic logic signed [VALUE_BITS-1:0] pick_number();
    logic signed [VALUE_BITS-1:0] p;
    p = 1;
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 999);
      2: return -$signed(VALUE_BITS'($urandom_range(1, 99999)));
      3: begin
        // values around a power of ten, either sign
        repeat ($urandom_range(0, 9)) p = p * 10;
        p = p + $urandom_range(0, 2) - 1;
        return $urandom_range(0, 1) ? -p : p;
      end
      default: begin
        case ($urandom_range(0, 3))
          0: return {1'b1, {(VALUE_BITS-1){1'b0}}};
          1: return {1'b0, {(VALUE_BITS-1){1'b1}}};
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  initial begin
    rst           <= 1'b1;
    start         <= 1'b0;
    number        <= '0;
    cfg_write     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    words_sent    = 0;
    settings_used = 1;
    burst         = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset format first, then the width and sign extremes.
    send_word(0);
    send_word(1);
    send_word(-1);
    send_word(32'sh7fffffff);
    send_word(32'sh80000000);
    send_word(1000000005);
    send_word(-90807);
    set_format(1, 1'b1);
    send_word(-5);
    send_word(7);
    send_word(32'sh7fffffff);
    set_format(16, 1'b1);
    burst = 1'b1;
    send_word(32'sh80000000);
    send_word(0);
    send_word(32'sh7fffffff);
    burst = 1'b0;
    set_format(0, 1'b0);
    send_word(42);
    send_word(-3);
    set_format(31, 1'b0);
    send_word(-1);
    send_word(32'sh80000000);
    send_word(-1000);
    set_format(12, 1'b1);
    send_word(32'sh80000000);
    send_word(32'sh80000001);

    // Random phases, each with its own register setting and pacing.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if ($urandom_range(0, 3) == 0)
        set_format($urandom_range(0, 31), 1'($urandom_range(0, 1)));
      else
        set_format($urandom_range(1, 16), 1'($urandom_range(0, 1)));
      burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_WORDS; i++)
        send_word(pick_number());
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Formatted %0d words under %0d register settings, %0d bytes checked.",
             words_sent, settings_used, bytes_seen);
    if (fail_count == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/itd_pkg.sv
rtl/core/itd_dab_stage.sv
rtl/core/itd_text.sv
rtl/core/itd_serializer.sv
rtl/core/int_to_decimal_text.sv
dv/itd_checker.sv
dv/tb.sv
